FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and fixed widths of the sorted priority queue with budget.
// ----------------------------------------------------------------------------
package spq_pkg;

  // command codes
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_INSERT = 3'd0;
  localparam cmd_t CMD_POP    = 3'd1;
  localparam cmd_t CMD_PEEK   = 3'd2;
  localparam cmd_t CMD_SEARCH = 3'd3;
  localparam cmd_t CMD_SELECT = 3'd4;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;
  localparam status_t STAT_MISS  = 2'd3;

  // fixed widths
  localparam int OCC_W   = 5;
  localparam int CAP_W   = 5;
  localparam int LIMIT_W = 20;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register file: index is the word address bit
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_REG_CAPACITY = 1'b0;
  localparam cfg_idx_t CFG_REG_LIMIT    = 1'b1;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd400;

endpackage

FILE: hdl/spq_in_if.sv
// ----------------------------------------------------------------------------
// spq_in_if
// Command channel: valid/ready handshake with command, id and quantity.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int ID_BITS  = 16,
  parameter int QTY_BITS = 16
) ();
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [ID_BITS-1:0]  item_id;
  logic [QTY_BITS-1:0] item_qty;

  modport source (output valid, cmd, item_id, item_qty, input ready);
  modport sink   (input valid, cmd, item_id, item_qty, output ready);
endinterface

FILE: hdl/spq_out_if.sv
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: valid/ready handshake with status and entry fields.
// ----------------------------------------------------------------------------
interface spq_out_if
  import spq_pkg::*;
#(
  parameter int ID_BITS  = 16,
  parameter int QTY_BITS = 16
) ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [ID_BITS-1:0]  out_id;
  logic [QTY_BITS-1:0] out_qty;
  logic                admitted;
  logic                last;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_id, out_qty, admitted, last, occupancy,
                  input ready);
  modport sink   (input valid, status, out_id, out_qty, admitted, last, occupancy,
                  output ready);
endinterface

FILE: hdl/sorted_priority_queue_with_budget.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_budget
// Bounded queue of (id, quantity) entries in descending quantity order,
// held as a ring in one RAM, with pop, peek, search and budget selection.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        cmd, item_id, item_qty
//  out_ch    source     valid/ready        status, out_id, out_qty, admitted,
//                                          last, occupancy
//  cfg_*     slave      APB, pready high   capacity (0x0), qty_limit (0x4)
//
//  One command at a time. Error, unknown and empty cases, pop and peek
//  give a single result. Insert into an empty queue writes the entry
//  straight to the tail slot, else it walks back from the tail, and search
//  walks from the head: both touch one stored entry per cycle through the RAM read port.
//  Budget select gives one result per entry, one per cycle while the output is not stalled.
//  rst_n is synchronous: the queue empties, registers return to 15 and 400.
//  A stalled result holds in the output register; the walk waits with it.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_budget
  import spq_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int QTY_BITS    = 16,
  parameter int ID_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  spq_in_if.sink            in_ch,
  spq_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW      = $clog2(MAX_ENTRIES);
  localparam int W       = ID_BITS + QTY_BITS;
  localparam int TOT_W   = (QTY_BITS + OCC_W > LIMIT_W) ? QTY_BITS + OCC_W : LIMIT_W;
  localparam int CAP_LIM = (MAX_ENTRIES > 31) ? 31 : MAX_ENTRIES;
  localparam int SW      = AW + OCC_W + 1;
  localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(CAP_LIM);
  localparam logic [AW-1:0]    PTR_LAST = AW'(MAX_ENTRIES - 1);

  // sequencer states
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_INS_CMP = 3'd1;
  localparam logic [ST_W-1:0] ST_INS_PUT = 3'd2;
  localparam logic [ST_W-1:0] ST_FRONT   = 3'd3;
  localparam logic [ST_W-1:0] ST_SRCH    = 3'd4;
  localparam logic [ST_W-1:0] ST_WALK    = 3'd5;
  localparam logic [ST_W-1:0] ST_RESP    = 3'd6;

  logic [ST_W-1:0]     state_r, state_nxt;
  logic [OCC_W-1:0]    count_r, count_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       hole_r, hole_nxt;
  logic [OCC_W-1:0]    rem_r, rem_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [QTY_BITS-1:0] qty_r, qty_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ID_BITS-1:0]  res_id_r, res_id_nxt;
  logic [QTY_BITS-1:0] res_qty_r, res_qty_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ID_BITS-1:0]  out_id_r, out_id_nxt;
  logic [QTY_BITS-1:0] out_qty_r, out_qty_nxt;
  logic                out_adm_r, out_adm_nxt;
  logic                out_last_r, out_last_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;
  logic [CAP_W-1:0]    capacity_r, capacity_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [W-1:0]        ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [W-1:0]        ram_rdata;
  logic [ID_BITS-1:0]  rd_id;
  logic [QTY_BITS-1:0] rd_qty;

  logic                in_fire;
  logic                slot_free;
  logic                cfg_wr;
  logic [CAP_W-1:0]    cap_eff;
  logic [TOT_W-1:0]    walk_sum;
  logic                walk_fits;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? PTR_LAST : p - AW'(1);
  endfunction

  // entry store
  spq_ram #(
    .WIDTH (W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id  = ram_rdata[W-1:QTY_BITS];
  assign rd_qty = ram_rdata[QTY_BITS-1:0];

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && (state_r == ST_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.out_qty   = out_qty_r;
  assign out_ch.admitted  = out_adm_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.occupancy = out_occ_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx_t'(cfg_paddr[2]))
      CFG_REG_CAPACITY: cfg_prdata = APB_DW'(capacity_r);
      CFG_REG_LIMIT:    cfg_prdata = APB_DW'(limit_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // effective capacity and budget arithmetic
  assign cap_eff   = (capacity_r < CAP_MAX) ? capacity_r : CAP_MAX;
  assign walk_sum  = total_r + TOT_W'(rd_qty);
  assign walk_fits = (walk_sum <= TOT_W'(limit_r));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    rd_ptr_nxt     = rd_ptr_r;
    hole_nxt       = hole_r;
    rem_nxt        = rem_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    qty_nxt        = qty_r;
    total_nxt      = total_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_qty_nxt    = res_qty_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_qty_nxt    = out_qty_r;
    out_adm_nxt    = out_adm_r;
    out_last_nxt   = out_last_r;
    out_occ_nxt    = out_occ_r;
    capacity_nxt   = capacity_r;
    limit_nxt      = limit_r;
    ram_we         = 1'b0;
    ram_waddr      = hole_r;
    ram_wdata      = {id_r, qty_r};
    ram_re         = 1'b0;
    ram_raddr      = rd_ptr_r;

    // register writes
    if (cfg_wr) begin
      if (cfg_idx_t'(cfg_paddr[2]) == CFG_REG_CAPACITY) begin
        capacity_nxt = cfg_pwdata[CAP_W-1:0];
      end else begin
        limit_nxt = cfg_pwdata[LIMIT_W-1:0];
      end
    end

    unique case (state_r)
      // take a command and start its first access
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_ch.cmd;
          id_nxt         = in_ch.item_id;
          qty_nxt        = in_ch.item_qty;
          res_status_nxt = STAT_OK;
          res_id_nxt     = '0;
          res_qty_nxt    = '0;
          total_nxt      = '0;
          rem_nxt        = count_r - OCC_W'(1);
          state_nxt      = ST_RESP;
          unique case (in_ch.cmd)
            CMD_INSERT: begin
              if (count_r >= cap_eff) begin
                res_status_nxt = STAT_FULL;
              end else if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                ram_wdata = {in_ch.item_id, in_ch.item_qty};
                tail_nxt  = ptr_inc(tail_r);
                count_nxt = count_r + OCC_W'(1);
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_dec(tail_r);
                rd_ptr_nxt = ptr_dec(tail_r);
                hole_nxt   = tail_r;
                state_nxt  = ST_INS_CMP;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                state_nxt = ST_FRONT;
              end
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_MISS;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                rd_ptr_nxt = head_r;
                state_nxt  = ST_SRCH;
              end
            end
            CMD_SELECT: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = head_r;
                rd_ptr_nxt = head_r;
                state_nxt  = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // walk back from the tail, moving smaller entries up one slot
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_qty < qty_r) begin
          ram_waddr = hole_r;
          ram_wdata = ram_rdata;
          hole_nxt  = rd_ptr_r;
          if (rem_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = ptr_dec(rd_ptr_r);
            rd_ptr_nxt = ptr_dec(rd_ptr_r);
            rem_nxt    = rem_r - OCC_W'(1);
          end
        end else begin
          ram_waddr = hole_r;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + OCC_W'(1);
          state_nxt = ST_RESP;
        end
      end

      // every entry moved: new one goes to the front slot
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = hole_r;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + OCC_W'(1);
        state_nxt = ST_RESP;
      end

      // front entry read back for pop or peek
      ST_FRONT: begin
        res_id_nxt  = rd_id;
        res_qty_nxt = rd_qty;
        if (cmd_r == CMD_POP) begin
          head_nxt  = ptr_inc(head_r);
          count_nxt = count_r - OCC_W'(1);
        end
        state_nxt = ST_RESP;
      end

      // id search, front to back
      ST_SRCH: begin
        if (rd_id == id_r) begin
          res_id_nxt = id_r;
          state_nxt  = ST_RESP;
        end else if (rem_r == '0) begin
          res_status_nxt = STAT_MISS;
          state_nxt      = ST_RESP;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = ptr_inc(rd_ptr_r);
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          rem_nxt    = rem_r - OCC_W'(1);
        end
      end

      // budget walk, one result per entry
      ST_WALK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_id_nxt     = rd_id;
          out_qty_nxt    = rd_qty;
          out_adm_nxt    = walk_fits;
          out_last_nxt   = (rem_r == '0);
          out_occ_nxt    = count_r;
          if (walk_fits) begin
            total_nxt = walk_sum;
          end
          if (rem_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = ptr_inc(rd_ptr_r);
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            rem_nxt    = rem_r - OCC_W'(1);
          end
        end
      end

      // single result into the output register
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_qty_nxt    = res_qty_r;
          out_adm_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          out_occ_nxt    = count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      capacity_r  <= capacity_nxt;
      limit_r     <= limit_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    hole_r       <= hole_nxt;
    rem_r        <= rem_nxt;
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    qty_r        <= qty_nxt;
    total_r      <= total_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_qty_r    <= res_qty_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_qty_r    <= out_qty_nxt;
    out_adm_r    <= out_adm_nxt;
    out_last_r   <= out_last_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // ring bookkeeping check: tail sits count slots past head
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_chk;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    tail_chk = (tail_sum >= SW'(MAX_ENTRIES)) ? tail_sum - SW'(MAX_ENTRIES) : tail_sum;
  end

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == tail_chk[AW-1:0])
    else $error("tail pointer out of step with head and count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_MAX)
    else $error("entry count beyond the ring size");

  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != ST_IDLE)
    else $error("accepted command produced no work");

  a_admit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_adm_r |-> out_status_r == STAT_OK)
    else $error("admitted flag on an error result");

endmodule

FILE: hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
